### rtl/bs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bs_pkg: shared types and constants of the bubble sorter
// Capacity, derived widths, sequencer states and the control bundle.
// ----------------------------------------------------------------------------
package bs_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int DATA_W    = 32;
	localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

	typedef enum logic [2:0] {
		S_FILL,
		S_P0,
		S_P1,
		S_CMP,
		S_WB,
		S_ERD,
		S_EOUT
	} state_t;

	// store write data source
	typedef enum logic [1:0] {
		WS_IN,
		WS_MIN,
		WS_CUR
	} wsrc_t;

	// carried (bubbling) element update
	typedef enum logic [1:0] {
		CUR_HOLD,
		CUR_LOAD,
		CUR_MAX
	} cur_op_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		wsrc_t            wsrc;
		logic [IDX_W-1:0] raddr;
		cur_op_t          cur_op;
		logic             out_load;
		logic             out_last;
		logic             out_ovf;
	} ctl_t;

endpackage
`default_nettype wire

### rtl/bs_cmp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bs_cmp: compare-and-swap unit
// Signed compare of the carried element against the next stored one.
// ----------------------------------------------------------------------------
module bs_cmp (
	input  wire logic signed [bs_pkg::DATA_W-1:0] cur,
	input  wire logic signed [bs_pkg::DATA_W-1:0] nxt,
	output logic signed [bs_pkg::DATA_W-1:0]      min_v,
	output logic signed [bs_pkg::DATA_W-1:0]      max_v
);

	logic less;

	// swap only on strictly smaller: equal values keep arrival order
	assign less  = (nxt < cur);
	assign min_v = less ? nxt : cur;
	assign max_v = less ? cur : nxt;

endmodule
`default_nettype wire

### rtl/bs_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bs_seq: bubble sorter sequencer
// Fill counting, pass and index counters, emission stepping.
// ----------------------------------------------------------------------------
module bs_seq (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire logic    item_last,
	output logic         in_ready,
	input  wire logic    out_free,
	output bs_pkg::ctl_t ctl
);

	bs_pkg::state_t                 state_q, state_d;
	logic [bs_pkg::CNT_W-1:0]       count_q, count_d;
	logic [bs_pkg::CNT_W-1:0]       n_q, n_d;
	logic [bs_pkg::CNT_W-1:0]       pass_q, pass_d;
	logic [bs_pkg::IDX_W-1:0]       k_q, k_d;
	logic                           dropped_q, dropped_d;
	logic [bs_pkg::CNT_W-1:0]       n_dec;
	logic [bs_pkg::CNT_W-1:0]       n_new;
	logic [bs_pkg::IDX_W-1:0]       last_idx;
	logic                           room;

	assign n_dec    = n_q - bs_pkg::CNT_W'(1);
	assign last_idx = n_dec[bs_pkg::IDX_W-1:0];
	assign room     = (count_q < bs_pkg::CNT_W'(bs_pkg::MAX_ITEMS));
	assign n_new    = room ? (count_q + bs_pkg::CNT_W'(1)) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bs_pkg::S_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			n_q       <= '0;
			pass_q    <= '0;
			k_q       <= '0;
			dropped_q <= 1'b0;
		end else begin
			count_q   <= count_d;
			n_q       <= n_d;
			pass_q    <= pass_d;
			k_q       <= k_d;
			dropped_q <= dropped_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		n_d          = n_q;
		pass_d       = pass_q;
		k_d          = k_q;
		dropped_d    = dropped_q;
		in_ready     = 1'b0;
		ctl.we       = 1'b0;
		ctl.waddr    = k_q - bs_pkg::IDX_W'(1);
		ctl.wsrc     = bs_pkg::WS_IN;
		ctl.raddr    = k_q;
		ctl.cur_op   = bs_pkg::CUR_HOLD;
		ctl.out_load = 1'b0;
		ctl.out_last = 1'b0;
		ctl.out_ovf  = dropped_q;
		case (state_q)
			bs_pkg::S_FILL: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (room) begin
						ctl.we    = 1'b1;
						ctl.waddr = count_q[bs_pkg::IDX_W-1:0];
						ctl.wsrc  = bs_pkg::WS_IN;
						count_d   = count_q + bs_pkg::CNT_W'(1);
					end else begin
						dropped_d = 1'b1;
					end
					if (item_last) begin
						n_d     = n_new;
						pass_d  = n_new - bs_pkg::CNT_W'(1);
						k_d     = '0;
						state_d = (n_new > bs_pkg::CNT_W'(1)) ? bs_pkg::S_P0 : bs_pkg::S_ERD;
					end
				end
			end
			bs_pkg::S_P0: begin
				ctl.raddr = '0;
				state_d   = bs_pkg::S_P1;
			end
			bs_pkg::S_P1: begin
				ctl.cur_op = bs_pkg::CUR_LOAD;
				ctl.raddr  = bs_pkg::IDX_W'(1);
				k_d        = bs_pkg::IDX_W'(1);
				state_d    = bs_pkg::S_CMP;
			end
			bs_pkg::S_CMP: begin
				ctl.we     = 1'b1;
				ctl.waddr  = k_q - bs_pkg::IDX_W'(1);
				ctl.wsrc   = bs_pkg::WS_MIN;
				ctl.cur_op = bs_pkg::CUR_MAX;
				ctl.raddr  = k_q + bs_pkg::IDX_W'(1);
				k_d        = k_q + bs_pkg::IDX_W'(1);
				if (k_q == last_idx) begin
					state_d = bs_pkg::S_WB;
				end
			end
			bs_pkg::S_WB: begin
				ctl.we    = 1'b1;
				ctl.waddr = last_idx;
				ctl.wsrc  = bs_pkg::WS_CUR;
				pass_d    = pass_q - bs_pkg::CNT_W'(1);
				if (pass_q == bs_pkg::CNT_W'(1)) begin
					k_d     = '0;
					state_d = bs_pkg::S_ERD;
				end else begin
					state_d = bs_pkg::S_P0;
				end
			end
			bs_pkg::S_ERD: begin
				state_d = bs_pkg::S_EOUT;
			end
			bs_pkg::S_EOUT: begin
				if (out_free) begin
					ctl.out_load = 1'b1;
					ctl.out_last = (k_q == last_idx);
					if (k_q == last_idx) begin
						count_d   = '0;
						dropped_d = 1'b0;
						state_d   = bs_pkg::S_FILL;
					end else begin
						k_d     = k_q + bs_pkg::IDX_W'(1);
						state_d = bs_pkg::S_ERD;
					end
				end
			end
			default: begin
				state_d = bs_pkg::S_FILL;
			end
		endcase
	end

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= bs_pkg::CNT_W'(bs_pkg::MAX_ITEMS))
		else $error("fill count beyond capacity");

	a_cmp_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bs_pkg::S_CMP) |-> ({1'b0, k_q} < n_q))
		else $error("compare index outside stored set");

	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && item_last) |=> !in_ready)
		else $error("request taken straight after end of set");

endmodule
`default_nettype wire

### rtl/bubble_sorter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bubble_sorter: stable ascending sort of sets of signed 32-bit values
// Stores a set, sorts it in place with one shared compare-swap unit,
// then streams it out with the final element and overflow flagged.
// ----------------------------------------------------------------------------
//
//  channel | handshake                 | payload
//  --------+---------------------------+-----------------------------------
//  in      | in_valid / in_ready       | item_value, item_last
//  out     | out_valid / out_ready     | sorted_value, sorted_last, overflow
//
// A set of n stored values is loaded one accepted request at a time, then
// sorted in n-1 passes (one compare-swap per cycle, with P0, P1 and WB as
// turnaround states around each pass on the single-read, single-write
// store), and emitted through the ERD and EOUT states for each result.
// in_ready is high only while a set is being loaded; it drops after the
// request that closes a set and returns once the last result is loaded
// into the output register, so a new set can start while it waits.
// Reset clears the sequencer and output valid; the store needs no clearing.
// Requests past capacity are dropped and flag overflow on that set.
// ----------------------------------------------------------------------------
module bubble_sorter (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic signed [bs_pkg::DATA_W-1:0]  item_value,
	input  wire logic                              item_last,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [bs_pkg::DATA_W-1:0]       sorted_value,
	output logic                                   sorted_last,
	output logic                                   overflow
);

	bs_pkg::ctl_t                    ctl;
	logic                            out_free;
	logic [bs_pkg::DATA_W-1:0]       mem [bs_pkg::MAX_ITEMS];
	logic [bs_pkg::DATA_W-1:0]       rdata_q;
	logic [bs_pkg::DATA_W-1:0]       wdata;
	logic signed [bs_pkg::DATA_W-1:0] cur_q;
	logic signed [bs_pkg::DATA_W-1:0] cur_d;
	logic signed [bs_pkg::DATA_W-1:0] min_v;
	logic signed [bs_pkg::DATA_W-1:0] max_v;
	logic                            out_valid_q;
	logic signed [bs_pkg::DATA_W-1:0] sorted_value_q;
	logic                            sorted_last_q;
	logic                            overflow_q;

	// output slot can take a result this cycle
	assign out_free = !out_valid_q || out_ready;

	bs_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.item_last(item_last),
		.in_ready (in_ready),
		.out_free (out_free),
		.ctl      (ctl)
	);

	// shared compare-swap: carried element against the one just read
	bs_cmp u_cmp (
		.cur  (cur_q),
		.nxt  (rdata_q),
		.min_v(min_v),
		.max_v(max_v)
	);

	always_comb begin
		case (ctl.wsrc)
			bs_pkg::WS_IN:  wdata = item_value;
			bs_pkg::WS_MIN: wdata = min_v;
			bs_pkg::WS_CUR: wdata = cur_q;
			default:        wdata = item_value;
		endcase
	end

	always_comb begin
		case (ctl.cur_op)
			bs_pkg::CUR_HOLD: cur_d = cur_q;
			bs_pkg::CUR_LOAD: cur_d = rdata_q;
			bs_pkg::CUR_MAX:  cur_d = max_v;
			default:          cur_d = cur_q;
		endcase
	end

	// element store: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[ctl.waddr] <= wdata;
		end
		rdata_q <= mem[ctl.raddr];
	end

	// carried (largest so far) element of the current pass
	always_ff @(posedge clk) begin
		cur_q <= cur_d;
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			sorted_value_q <= rdata_q;
			sorted_last_q  <= ctl.out_last;
			overflow_q     <= ctl.out_ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign sorted_value = sorted_value_q;
	assign sorted_last  = sorted_last_q;
	assign overflow     = overflow_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken one");

	a_no_write_emit: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> !ctl.we)
		else $error("store written while a result is loaded");

	a_in_out_excl: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !ctl.out_load)
		else $error("loading a request while emitting");

endmodule
`default_nettype wire

### tb/tb_bubble_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bubble_sorter: self-checking bench for the bubble sorter
// Streams sets of signed values through the block, predicts each sorted
// set in a shadow store, and checks every result field in order.
// Handshake gaps and output back-pressure vary by phase.
// ----------------------------------------------------------------------------
module tb_bubble_sorter;

	localparam int STALL_LIMIT = 20000;	// above the quiet stretch of a full 64-set sort
	localparam int DRAIN_CYCLES = 200;
	localparam int SHOW_ERRORS = 10;
	localparam logic signed [bs_pkg::DATA_W-1:0] VAL_MIN =
		{1'b1, {(bs_pkg::DATA_W-1){1'b0}}};
	localparam logic signed [bs_pkg::DATA_W-1:0] VAL_MAX =
		{1'b0, {(bs_pkg::DATA_W-1){1'b1}}};

	typedef struct {
		logic signed [bs_pkg::DATA_W-1:0] value;
		logic                             last;
		int                               phase;
	} sort_req_t;

	typedef struct {
		logic signed [bs_pkg::DATA_W-1:0] value;
		logic                             last;
		logic                             ovf;
	} sorted_elem_t;

	// idle / stall percentages per phase: none, sender, receiver, both
	int in_idle_pct[4]   = '{0, 72, 0, 19};
	int out_stall_pct[4] = '{0, 0, 72, 19};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [bs_pkg::DATA_W-1:0] item_value = '0;
	logic item_last = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [bs_pkg::DATA_W-1:0] sorted_value;
	logic sorted_last;
	logic overflow;

	sort_req_t    req_q[$];		// requests not yet presented
	sorted_elem_t sorted_q[$];	// sorted results still owed by the block
	int cur_phase = 0;
	int n_errors = 0;

	// shadow of the set being loaded
	logic signed [bs_pkg::DATA_W-1:0] set_vals[bs_pkg::MAX_ITEMS];
	int   set_count = 0;
	logic set_dropped = 1'b0;

	bubble_sorter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.item_value   (item_value),
		.item_last    (item_last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sorted_value (sorted_value),
		.sorted_last  (sorted_last),
		.overflow     (overflow)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic log_mismatch(input string msg);
		n_errors++;
		if (n_errors <= SHOW_ERRORS)
			$display("%0t: %s", $realtime, msg);
	endtask

	// Absorb one accepted request; on the closing one, sort the set
	// (stable: swap only on strictly smaller) and queue the results.
	task automatic absorb_element(input logic signed [bs_pkg::DATA_W-1:0] v,
			input logic lst);
		logic signed [bs_pkg::DATA_W-1:0] tmp;
		sorted_elem_t e;
		if (set_count < bs_pkg::MAX_ITEMS) begin
			set_vals[set_count] = v;
			set_count++;
		end else begin
			set_dropped = 1'b1;
		end
		if (lst) begin
			for (int pass = 0; pass < set_count; pass++)
				for (int k = 1; k < set_count; k++)
					if (set_vals[k] < set_vals[k-1]) begin
						tmp = set_vals[k-1];
						set_vals[k-1] = set_vals[k];
						set_vals[k] = tmp;
					end
			for (int k = 0; k < set_count; k++) begin
				e.value = set_vals[k];
				e.last  = (k == set_count - 1);
				e.ovf   = set_dropped;
				sorted_q.push_back(e);
			end
			set_count = 0;
			set_dropped = 1'b0;
		end
	endtask

	task automatic push_req(input logic signed [bs_pkg::DATA_W-1:0] v, input logic lst,
			input int phase);
		sort_req_t r;
		r.value = v;
		r.last  = lst;
		r.phase = phase;
		req_q.push_back(r);
	endtask

	// One set of n requests with mixed content: full-range, clustered
	// small values (plenty of duplicates) and the range ends.
	task automatic queue_set(input int n, input int phase);
		logic signed [bs_pkg::DATA_W-1:0] v;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(3))
				0: v = $urandom_range(16) - 8;
				1: begin
					case ($urandom_range(3))
						0: v = VAL_MIN;
						1: v = VAL_MAX;
						2: v = '0;
						default: v = '1;
					endcase
				end
				default: v = $urandom;
			endcase
			push_req(v, i == n - 1, phase);
		end
	endtask

	// Driver: present queued requests, hold each until accepted, predict
	// at the accepting edge.
	always @(posedge clk) begin
		sort_req_t head;
		logic holding;
		holding = in_valid && !in_ready;
		if (in_valid && in_ready)
			absorb_element(item_value, item_last);
		if (!holding) begin
			if (arst_n && req_q.size() > 0
					&& $urandom_range(99) >= in_idle_pct[req_q[0].phase]) begin
				head = req_q.pop_front();
				in_valid   <= 1'b1;
				item_value <= head.value;
				item_last  <= head.last;
				cur_phase  <= head.phase;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: check each accepted result against the oldest expectation.
	always @(posedge clk) begin
		sorted_elem_t want;
		if (arst_n && out_valid && out_ready) begin
			if (sorted_q.size() == 0) begin
				log_mismatch($sformatf("unexpected result value=%0d last=%0b ovf=%0b",
					sorted_value, sorted_last, overflow));
			end else begin
				want = sorted_q.pop_front();
				if (sorted_value !== want.value || sorted_last !== want.last
						|| overflow !== want.ovf)
					log_mismatch($sformatf(
						"mismatch: exp value=%0d last=%0b ovf=%0b, got value=%0d last=%0b ovf=%0b",
						want.value, want.last, want.ovf,
						sorted_value, sorted_last, overflow));
			end
		end
		out_ready <= arst_n && ($urandom_range(99) >= out_stall_pct[cur_phase]);
	end

	// Watchdog: too long without any request or result moving.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : stimulus
		int items;
		// directed sets, no idling
		push_req(VAL_MIN, 1'b1, 0);			// single element, most negative
		push_req(VAL_MAX, 1'b1, 0);			// single element, most positive
		push_req(5, 1'b0, 0);				// pair, reversed
		push_req(3, 1'b1, 0);
		push_req(-1, 1'b0, 0);				// pair, already in order
		push_req(0, 1'b1, 0);
		push_req(VAL_MAX, 1'b0, 0);			// extremes, sign boundary, repeats
		push_req(VAL_MIN, 1'b0, 0);
		push_req(0, 1'b0, 0);
		push_req(-1, 1'b0, 0);
		push_req(1, 1'b0, 0);
		push_req(VAL_MAX, 1'b0, 0);
		push_req(VAL_MIN, 1'b0, 0);
		push_req(32'h5555_5555, 1'b0, 0);
		push_req(32'hAAAA_AAAA, 1'b0, 0);
		push_req(7, 1'b1, 0);
		push_req(4, 1'b0, 0);				// all equal
		push_req(4, 1'b0, 0);
		push_req(4, 1'b1, 0);

		// random small sets, one chunk per idling phase; one set past
		// capacity in the last phase drops its last two requests, the closing one among them
		for (int ph = 0; ph < 4; ph++) begin
			items = 0;
			while (items < 14) begin
				int n;
				n = $urandom_range(1, 8);
				queue_set(n, ph);
				items += n;
			end
			if (ph == 3)
				queue_set(bs_pkg::MAX_ITEMS + 2, ph);
			queue_set($urandom_range(1, 6), ph);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// wait until every request is taken and every result has come back
		while (req_q.size() > 0 || in_valid || sorted_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sorted_q.size() != 0)
			log_mismatch($sformatf("%0d results never arrived", sorted_q.size()));
		if (n_errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
